>>> design/pdcd_pkg.sv
// ============================================================================
// pdcd_pkg: shared types and constants for the PWM duty-cycle decoder
// Field widths, command codes, reset values and parameter defaults.
// ============================================================================
package pdcd_pkg;

    // Fixed field widths of the channel payloads
    localparam int TIME_FIELD_W = 48;
    localparam int CHAN_W       = 2;
    localparam int DUTY_W       = 8;

    // Number of duty fields carried by one result beat
    localparam int OUT_CH = 3;

    // Parameter defaults
    localparam int NUM_CHANNELS_DEF = 3;
    localparam int TIME_WIDTH_DEF   = 48;

    // Command codes
    localparam logic CMD_EDGE    = 1'b0;
    localparam logic CMD_REFRESH = 1'b1;

    // Duty values forced by a refresh
    localparam logic [DUTY_W-1:0] DUTY_FULL  = 8'hFF;
    localparam logic [DUTY_W-1:0] DUTY_EMPTY = 8'h00;

    // Idle timeout after reset
    localparam logic [TIME_FIELD_W-1:0] TIMEOUT_RESET = 48'd5000000;

    typedef logic [TIME_FIELD_W-1:0] time_field_t;
    typedef logic [DUTY_W-1:0]       duty_t;

endpackage

>>> design/pdcd_if.sv
// ============================================================================
// pdcd_if: valid/ready channels of the PWM duty-cycle decoder
// pdcd_in_if carries edge and refresh items; pdcd_out_if the duty beats.
// ============================================================================
interface pdcd_in_if;
    import pdcd_pkg::*;

    logic              valid;
    logic              ready;
    logic              cmd;
    logic [CHAN_W-1:0] channel;
    logic              level;
    time_field_t       time_ns;
    logic              red_pin;
    logic              green_pin;
    logic              blue_pin;

    modport source (
        output valid, cmd, channel, level, time_ns, red_pin, green_pin, blue_pin,
        input  ready
    );
    modport sink (
        input  valid, cmd, channel, level, time_ns, red_pin, green_pin, blue_pin,
        output ready
    );
endinterface

interface pdcd_out_if;
    import pdcd_pkg::*;

    logic  valid;
    logic  ready;
    duty_t red_duty;
    duty_t green_duty;
    duty_t blue_duty;

    modport source (
        output valid, red_duty, green_duty, blue_duty,
        input  ready
    );
    modport sink (
        input  valid, red_duty, green_duty, blue_duty,
        output ready
    );
endinterface

>>> design/pwm_duty_cycle_decoder_core.sv
// ============================================================================
// pwm_duty_cycle_decoder_core: PWM duty measurement on timestamped edges
// Tracks period and high time per channel and scales the duty to 0..255
// with a bit-serial restoring divider; refresh beats apply idle fallback.
// ============================================================================
//
//   port     dir   beat contents
//   -------  ----  ---------------------------------------------------------
//   item     in    cmd, channel, level, time_ns, red/green/blue pin levels
//   result   out   red_duty, green_duty, blue_duty (one beat per item)
//   cfg_*    in    timeout_ns write, taken on a rising clk edge with cfg_we high
//
// Edge item: an update runs S_EDGE, S_CHECK, then eight S_DIV steps (one
// quotient bit per cycle) before S_DONE; a skipped update leaves after
// S_CHECK, no rise seen after S_EDGE, a channel out of range goes straight
// to S_DONE. Refresh: one channel per cycle through the timeout compare.
// One item in flight; the next is taken while the result beat still waits.
// rst_n clears all channel state to zero and timeout_ns to 5,000,000.
//
module pwm_duty_cycle_decoder_core
#(
    parameter int NUM_CHANNELS = pdcd_pkg::NUM_CHANNELS_DEF,
    parameter int TIME_WIDTH   = pdcd_pkg::TIME_WIDTH_DEF
)
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_we,
    input  logic [pdcd_pkg::TIME_FIELD_W-1:0]     cfg_wdata,
    pdcd_in_if.sink                               item,
    pdcd_out_if.source                            result
);
    import pdcd_pkg::*;

    localparam int CIW   = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam int CMP_W = (TIME_WIDTH > TIME_FIELD_W) ? TIME_WIDTH : TIME_FIELD_W;
    localparam int QCW   = $clog2(DUTY_W);

    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_EDGE    = 3'd1;
    localparam logic [2:0] S_CHECK   = 3'd2;
    localparam logic [2:0] S_DIV     = 3'd3;
    localparam logic [2:0] S_REFRESH = 3'd4;
    localparam logic [2:0] S_DONE    = 3'd5;

    typedef logic [TIME_WIDTH-1:0] tval_t;

    // Control
    logic [2:0]       state_reg, state_next;
    logic [CIW-1:0]   idx_reg;
    logic [QCW-1:0]   bit_cnt_reg;
    logic             out_valid_reg;

    // Latched item
    logic             level_reg;
    tval_t            now_reg;
    logic [OUT_CH-1:0] pins_reg;

    // Configuration
    time_field_t      timeout_reg;

    // Channel state
    tval_t            rise_reg   [NUM_CHANNELS];
    tval_t            period_reg [NUM_CHANNELS];
    tval_t            high_reg   [NUM_CHANNELS];
    tval_t            last_reg   [NUM_CHANNELS];
    duty_t            duty_reg   [NUM_CHANNELS];

    // Divider
    tval_t            rem_reg;
    tval_t            dvs_reg;
    logic [DUTY_W-1:0] lo_reg;
    logic [DUTY_W-1:0] quo_reg;

    // Output beat
    duty_t            out_duty_reg [OUT_CH];

    // ------------------------------------------------------------------
    // Datapath terms
    // ------------------------------------------------------------------
    logic             item_acc;
    logic             chan_ok;
    tval_t            cur_rise, cur_last, cur_period, cur_high;
    tval_t            rise_diff, last_diff;
    logic             timed_out;
    logic             pin_sel;
    logic [TIME_WIDTH+DUTY_W-1:0] num_full;
    logic             upd_ok;
    logic [TIME_WIDTH:0] rem_sh, rem_sub;
    logic             quo_bit;
    logic [DUTY_W-1:0] quo_next;
    logic             out_free;

    assign item_acc   = item.valid && item.ready;
    assign item.ready = (state_reg == S_IDLE);
    assign chan_ok    = (5'(item.channel) < 5'(NUM_CHANNELS));

    assign cur_rise   = rise_reg[idx_reg];
    assign cur_last   = last_reg[idx_reg];
    assign cur_period = period_reg[idx_reg];
    assign cur_high   = high_reg[idx_reg];

    assign rise_diff  = now_reg - cur_rise;
    assign last_diff  = now_reg - cur_last;
    assign timed_out  = (cur_last == '0) || (CMP_W'(last_diff) > CMP_W'(timeout_reg));

    // Pin of the channel under refresh; channels without a pin read low
    always_comb
    begin
        pin_sel = 1'b0;
        for (int i = 0; i < OUT_CH; i++)
        begin
            if (32'(idx_reg) == i)
            begin
                pin_sel = pins_reg[i];
            end
        end
    end

    // high * 255 and the duty update condition
    assign num_full = {cur_high, {DUTY_W{1'b0}}} - {{DUTY_W{1'b0}}, cur_high};
    assign upd_ok   = (cur_period != '0) && (cur_high <= cur_period);

    // One restoring division step
    assign rem_sh   = {rem_reg, lo_reg[DUTY_W-1]};
    assign rem_sub  = rem_sh - {1'b0, dvs_reg};
    assign quo_bit  = (rem_sh >= {1'b0, dvs_reg});
    assign quo_next = {quo_reg[DUTY_W-2:0], quo_bit};

    assign out_free = !out_valid_reg || result.ready;

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (item_acc)
                begin
                    if (item.cmd == CMD_REFRESH)
                    begin
                        state_next = S_REFRESH;
                    end
                    else if (chan_ok)
                    begin
                        state_next = S_EDGE;
                    end
                    else
                    begin
                        state_next = S_DONE;
                    end
                end
            end
            S_EDGE:
            begin
                state_next = (cur_rise != '0) ? S_CHECK : S_DONE;
            end
            S_CHECK:
            begin
                state_next = upd_ok ? S_DIV : S_DONE;
            end
            S_DIV:
            begin
                if (bit_cnt_reg == QCW'(DUTY_W - 1))
                begin
                    state_next = S_DONE;
                end
            end
            S_REFRESH:
            begin
                if (idx_reg == CIW'(NUM_CHANNELS - 1))
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            idx_reg       <= '0;
            bit_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
            timeout_reg   <= TIMEOUT_RESET;
        end
        else
        begin
            state_reg <= state_next;

            if (cfg_we)
            begin
                timeout_reg <= cfg_wdata;
            end

            // Channel index: edge channel, or refresh sweep
            if (item_acc)
            begin
                idx_reg <= (item.cmd == CMD_REFRESH) ? '0 : CIW'(item.channel);
            end
            else if (state_reg == S_REFRESH && idx_reg != CIW'(NUM_CHANNELS - 1))
            begin
                idx_reg <= idx_reg + 1'b1;
            end

            // Quotient bit counter
            if (state_reg == S_DIV)
            begin
                bit_cnt_reg <= bit_cnt_reg + 1'b1;
            end
            else
            begin
                bit_cnt_reg <= '0;
            end

            // Result beat handshake
            if (state_reg == S_DONE && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Latched item fields
    always_ff @(posedge clk)
    begin
        if (item_acc)
        begin
            level_reg <= item.level;
            now_reg   <= TIME_WIDTH'(item.time_ns);
            pins_reg  <= {item.blue_pin, item.green_pin, item.red_pin};
        end
    end

    // ------------------------------------------------------------------
    // Channel state
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_CHANNELS; i++)
            begin
                rise_reg[i]   <= '0;
                period_reg[i] <= '0;
                high_reg[i]   <= '0;
                last_reg[i]   <= '0;
                duty_reg[i]   <= '0;
            end
        end
        else
        begin
            unique case (state_reg)
                S_EDGE:
                begin
                    last_reg[idx_reg] <= now_reg;
                    if (level_reg)
                    begin
                        rise_reg[idx_reg] <= now_reg;
                        if (cur_rise != '0)
                        begin
                            period_reg[idx_reg] <= rise_diff;
                        end
                    end
                    else if (cur_rise != '0)
                    begin
                        high_reg[idx_reg] <= rise_diff;
                    end
                end
                S_DIV:
                begin
                    if (bit_cnt_reg == QCW'(DUTY_W - 1))
                    begin
                        duty_reg[idx_reg] <= quo_next;
                    end
                end
                S_REFRESH:
                begin
                    if (timed_out)
                    begin
                        duty_reg[idx_reg] <= pin_sel ? DUTY_FULL : DUTY_EMPTY;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Bit-serial divider: floor(high * 255 / period), one bit per cycle
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (state_reg == S_CHECK)
        begin
            rem_reg <= num_full[TIME_WIDTH+DUTY_W-1:DUTY_W];
            lo_reg  <= num_full[DUTY_W-1:0];
            dvs_reg <= cur_period;
            quo_reg <= '0;
        end
        else if (state_reg == S_DIV)
        begin
            rem_reg <= quo_bit ? rem_sub[TIME_WIDTH-1:0] : rem_sh[TIME_WIDTH-1:0];
            lo_reg  <= {lo_reg[DUTY_W-2:0], 1'b0};
            quo_reg <= quo_next;
        end
    end

    // ------------------------------------------------------------------
    // Result beat
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (state_reg == S_DONE && out_free)
        begin
            for (int i = 0; i < OUT_CH; i++)
            begin
                out_duty_reg[i] <= (i < NUM_CHANNELS) ? duty_reg[i] : DUTY_EMPTY;
            end
        end
    end

    assign result.valid      = out_valid_reg;
    assign result.red_duty   = out_duty_reg[0];
    assign result.green_duty = out_duty_reg[1];
    assign result.blue_duty  = out_duty_reg[2];

endmodule

>>> bench/pdcd_duty_checker.sv
`timescale 1ns / 1ps
// ============================================================================
// pdcd_duty_checker: duty predictor and beat comparator
// Watches the item, result and timeout-write ports of the PWM duty-cycle
// decoder. It keeps its own copy of the per-channel edge state, predicts
// the three duty bytes for every accepted item, and compares each result
// beat with the oldest prediction. It reports mismatch totals and the
// number of beats still owed.
// ============================================================================
module pdcd_duty_checker
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  pdcd_pkg::time_field_t cfg_wdata,
    pdcd_in_if                    item,
    pdcd_out_if                   result,
    output int                    fail_count,
    output int                    pending_beats
);
    import pdcd_pkg::*;

    localparam int NCH         = NUM_CHANNELS_DEF;
    localparam int MAX_REPORTS = 10;

    typedef struct packed {
        duty_t red;
        duty_t green;
        duty_t blue;
    } duty_set_t;

    // Predicted channel state
    time_field_t timeout_ns;
    time_field_t rise_at      [NCH];
    time_field_t period_len   [NCH];
    time_field_t high_len     [NCH];
    time_field_t last_edge_at [NCH];
    duty_t       duty_now     [NCH];

    duty_set_t   expected_duties [$];
    duty_set_t   got_beat;
    duty_set_t   want_beat;
    int          mismatch_total;

    // floor(high * 255 / period); high <= period keeps the quotient in 8 bits
    function automatic duty_t scaled_duty(time_field_t high, time_field_t period);
        logic [TIME_FIELD_W+7:0] num;
        logic [TIME_FIELD_W+7:0] quot;
        num  = ({8'd0, high} << 8) - {8'd0, high};
        quot = num / {8'd0, period};
        return quot[DUTY_W-1:0];
    endfunction

    function automatic void retune_duty(int ch);
        if (period_len[ch] != '0 && high_len[ch] <= period_len[ch])
            duty_now[ch] = scaled_duty(high_len[ch], period_len[ch]);
    endfunction

    // Advance the channel state by one item and queue the duty beat it yields
    function automatic void predict_duties(logic cmd, logic [CHAN_W-1:0] ch, logic level,
                                           time_field_t now, logic [OUT_CH-1:0] pins);
        duty_set_t beat;
        time_field_t idle_for;
        if (cmd == CMD_EDGE) begin
            if (ch < NCH) begin
                last_edge_at[ch] = now;
                if (level) begin
                    if (rise_at[ch] != '0) begin
                        period_len[ch] = now - rise_at[ch];
                        retune_duty(ch);
                    end
                    rise_at[ch] = now;
                end
                else if (rise_at[ch] != '0) begin
                    high_len[ch] = now - rise_at[ch];
                    retune_duty(ch);
                end
            end
        end
        else begin
            // stale or never-driven channels fall back to the static pin
            for (int i = 0; i < NCH; i++) begin
                idle_for = now - last_edge_at[i];
                if (last_edge_at[i] == '0 || idle_for > timeout_ns)
                    duty_now[i] = pins[i] ? DUTY_FULL : DUTY_EMPTY;
            end
        end
        beat.red   = duty_now[0];
        beat.green = duty_now[1];
        beat.blue  = duty_now[2];
        expected_duties.push_back(beat);
    endfunction

    // Sample all three ports at the rising edge
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            timeout_ns = TIMEOUT_RESET;
            for (int i = 0; i < NCH; i++) begin
                rise_at[i]      = '0;
                period_len[i]   = '0;
                high_len[i]     = '0;
                last_edge_at[i] = '0;
                duty_now[i]     = '0;
            end
            expected_duties.delete();
            mismatch_total = 0;
            pending_beats <= 0;
            fail_count    <= 0;
        end
        else begin
            if (cfg_we)
                timeout_ns = cfg_wdata;

            // result beat against the oldest prediction
            if (result.valid && result.ready) begin
                got_beat = {result.red_duty, result.green_duty, result.blue_duty};
                if (expected_duties.size() == 0) begin
                    mismatch_total++;
                    if (mismatch_total <= MAX_REPORTS)
                        $display("unexpected duty beat: r=%0d g=%0d b=%0d",
                                 got_beat.red, got_beat.green, got_beat.blue);
                end
                else begin
                    want_beat = expected_duties.pop_front();
                    if (got_beat !== want_beat) begin
                        mismatch_total++;
                        if (mismatch_total <= MAX_REPORTS)
                            $display("mismatch: expected r=%0d g=%0d b=%0d, got r=%0d g=%0d b=%0d",
                                     want_beat.red, want_beat.green, want_beat.blue,
                                     got_beat.red, got_beat.green, got_beat.blue);
                    end
                end
            end

            if (item.valid && item.ready)
                predict_duties(item.cmd, item.channel, item.level, item.time_ns,
                               {item.blue_pin, item.green_pin, item.red_pin});

            pending_beats <= expected_duties.size();
            fail_count    <= mismatch_total;
        end
    end

endmodule

>>> bench/testbench.sv
`timescale 1ns / 1ps
// ============================================================================
// testbench: regression for pwm_duty_cycle_decoder_core
// Drives a directed run over the edge and refresh corner cases, then six
// phases of random PWM edge trains with noise, each under its own timeout
// and one of four mixes of sender gaps and receiver stalls. The checker beside
// the block predicts and compares; this module only drives and judges.
// ============================================================================
module testbench;
    import pdcd_pkg::*;

    localparam int          CLK_HALF     = 4;
    localparam int          RESET_CYCLES = 5;
    localparam int          NUM_PHASES   = 6;
    localparam int          PHASE_BEATS  = 125;
    localparam int          HOLD_CYCLES  = 300;
    localparam int          SETTLE_GAP   = 16;
    localparam int          DRAIN_CYCLES = 40;
    localparam int          CYCLE_LIMIT  = 300000;
    localparam time_field_t TIME_MAX     = '1;

    localparam logic [CHAN_W-1:0] CH_RED    = 2'd0;
    localparam logic [CHAN_W-1:0] CH_GREEN  = 2'd1;
    localparam logic [CHAN_W-1:0] CH_BLUE   = 2'd2;
    localparam logic [CHAN_W-1:0] CH_UNUSED = 2'd3;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        cfg_we;
    time_field_t cfg_wdata;
    int          fail_count;
    int          pending_beats;
    int          cycle_count = 0;

    // idle controls shared with the result sink
    int          send_idle_pct;
    int          stall_pct;
    int          hold_requests;

    pdcd_in_if  item_if ();
    pdcd_out_if result_if ();

    pwm_duty_cycle_decoder_core u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .item      (item_if),
        .result    (result_if)
    );

    pdcd_duty_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .item          (item_if),
        .result        (result_if),
        .fail_count    (fail_count),
        .pending_beats (pending_beats)
    );

    always #(CLK_HALF) clk = ~clk;

    // Watchdog
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("pwm_duty_cycle_decoder_core regression: fail");
            $finish;
        end
    end

    // Result sink: random stalls, plus a long hold-off on request
    initial begin : result_sink
        int hold_seen;
        int hold_left;
        hold_seen = 0;
        hold_left = 0;
        result_if.ready = 1'b0;
        forever begin
            @(negedge clk);
            if (hold_requests != hold_seen) begin
                hold_seen = hold_requests;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                result_if.ready = 1'b0;
            end
            else
                result_if.ready = ($urandom_range(99) >= stall_pct);
        end
    end

    // One item beat, with optional sender gaps in front of it
    task automatic drive_beat(input logic cmd, input logic [CHAN_W-1:0] ch, input logic level,
                              input time_field_t stamp, input logic [2:0] pins);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct) begin
            item_if.valid = 1'b0;
            @(negedge clk);
        end
        item_if.valid     = 1'b1;
        item_if.cmd       = cmd;
        item_if.channel   = ch;
        item_if.level     = level;
        item_if.time_ns   = stamp;
        item_if.red_pin   = pins[0];
        item_if.green_pin = pins[1];
        item_if.blue_pin  = pins[2];
        do @(posedge clk); while (!item_if.ready);
    endtask

    // pin fields are don't-care on edge items
    task automatic edge_beat(input logic [CHAN_W-1:0] ch, input logic level,
                             input time_field_t stamp);
        drive_beat(CMD_EDGE, ch, level, stamp, 3'($urandom));
    endtask

    // channel and level are don't-care on refresh items; pins are {b, g, r}
    task automatic refresh_beat(input time_field_t stamp, input logic [2:0] pins);
        drive_beat(CMD_REFRESH, 2'($urandom), 1'($urandom), stamp, pins);
    endtask

    // Drop valid and wait until every predicted beat has come back
    task automatic drain_results();
        @(negedge clk);
        item_if.valid = 1'b0;
        wait (pending_beats == 0);
    endtask

    task automatic write_timeout(input time_field_t value);
        drain_results();
        repeat (SETTLE_GAP) @(negedge clk);
        cfg_we    = 1'b1;
        cfg_wdata = value;
        @(negedge clk);
        cfg_we    = 1'b0;
    endtask

    // Stimulus
    initial begin
        time_field_t clock_ns;
        time_field_t advance;
        time_field_t timeout_sel;
        logic [2:0]  pin_state;
        int          pick;
        int          ch;

        rst_n             = 1'b0;
        cfg_we            = 1'b0;
        cfg_wdata         = '0;
        item_if.valid     = 1'b0;
        item_if.cmd       = CMD_EDGE;
        item_if.channel   = CH_RED;
        item_if.level     = 1'b0;
        item_if.time_ns   = '0;
        item_if.red_pin   = 1'b0;
        item_if.green_pin = 1'b0;
        item_if.blue_pin  = 1'b0;
        send_idle_pct     = 0;
        stall_pct         = 0;
        hold_requests     = 0;

        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed corner cases under the reset timeout
        refresh_beat(48'd0, 3'b101);               // no edge seen yet
        edge_beat(CH_RED, 1'b0, 48'd100);          // fall with no rise
        edge_beat(CH_RED, 1'b1, 48'd0);            // rise at time zero does not count
        edge_beat(CH_RED, 1'b1, 48'd1000);
        edge_beat(CH_RED, 1'b0, 48'd1250);         // high time but no period yet
        edge_beat(CH_RED, 1'b1, 48'd2000);         // first real duty
        edge_beat(CH_RED, 1'b0, 48'd3000);         // high equals period
        edge_beat(CH_RED, 1'b1, 48'd3000);
        edge_beat(CH_RED, 1'b0, 48'd3000);         // zero high time
        edge_beat(CH_UNUSED, 1'b1, 48'd3100);      // channel out of range
        edge_beat(CH_UNUSED, 1'b0, 48'd3200);
        edge_beat(CH_GREEN, 1'b1, TIME_MAX - 48'd255);
        edge_beat(CH_GREEN, 1'b0, 48'h100);        // high time across the wrap
        edge_beat(CH_GREEN, 1'b1, 48'h300);
        edge_beat(CH_BLUE, 1'b1, 48'd10000);
        edge_beat(CH_BLUE, 1'b0, 48'd10500);
        edge_beat(CH_BLUE, 1'b1, 48'd10600);
        edge_beat(CH_BLUE, 1'b0, 48'd11300);       // high above period keeps duty
        refresh_beat(48'd11400, 3'b000);           // all channels recent
        refresh_beat(TIME_MAX, 3'b111);            // all channels stale
        edge_beat(CH_BLUE, 1'b1, TIME_MAX);
        edge_beat(CH_BLUE, 1'b0, 48'd0);           // fall at time zero after a rise

        clock_ns  = 48'd20000;
        pin_state = 3'b010;

        // Random phases: each with its own timeout and one of four idle mixes
        for (int phase_idx = 0; phase_idx < NUM_PHASES; phase_idx++) begin
            case (phase_idx)
                0:       timeout_sel = '0;
                1:       timeout_sel = TIME_MAX;
                2:       timeout_sel = 48'd20000;
                3:       timeout_sel = time_field_t'($urandom_range(200000, 1000));
                4:       timeout_sel = TIMEOUT_RESET;
                default: timeout_sel = 48'd1;
            endcase
            write_timeout(timeout_sel);

            @(posedge clk);
            case (phase_idx % 4)
                0:       begin send_idle_pct = 0;  stall_pct = 0;  end
                1:       begin send_idle_pct = 50; stall_pct = 0;  end
                2:       begin send_idle_pct = 0;  stall_pct = 50; end
                default: begin send_idle_pct = 26; stall_pct = 26; end
            endcase

            for (int n = 0; n < PHASE_BEATS; n++) begin
                // long receiver hold-off while items keep coming
                if ((phase_idx == 0 || phase_idx == 2) && n == 40)
                    hold_requests++;

                if ($urandom_range(9) == 0)
                    advance = time_field_t'({$urandom, $urandom});
                else
                    advance = time_field_t'($urandom_range(3000, 1));
                clock_ns = clock_ns + advance;
                pick = $urandom_range(99);

                if (pick < 75) begin
                    // well-formed toggle on one channel
                    ch = $urandom_range(2);
                    pin_state[ch] = ~pin_state[ch];
                    edge_beat(2'(ch), pin_state[ch], clock_ns);
                end
                else if (pick < 87) begin
                    if ($urandom_range(1) == 1)
                        refresh_beat(clock_ns, pin_state);
                    else
                        refresh_beat(clock_ns, 3'($urandom));
                end
                else if (pick < 92) begin
                    // same level again
                    ch = $urandom_range(2);
                    edge_beat(2'(ch), pin_state[ch], clock_ns);
                end
                else if (pick < 95)
                    edge_beat(CH_UNUSED, 1'($urandom), clock_ns);
                else if (pick < 97)
                    edge_beat(2'($urandom_range(2)), 1'($urandom), '0);
                else
                    drive_beat(1'($urandom), 2'($urandom), 1'($urandom),
                               time_field_t'({$urandom, $urandom}), 3'($urandom));
            end
        end

        drain_results();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("pwm_duty_cycle_decoder_core regression: pass");
        else
            $display("pwm_duty_cycle_decoder_core regression: fail");
        $finish;
    end

endmodule

>>> pwm_duty_cycle_decoder_core.f
design/pdcd_pkg.sv
design/pdcd_if.sv
design/pwm_duty_cycle_decoder_core.sv
bench/pdcd_duty_checker.sv
bench/testbench.sv
